FILE: hdl/lcs_pkg.sv
package lcs_pkg;

  localparam int unsigned DefWidth = 32;

  typedef struct packed {
    logic signed [DefWidth-1:0] coef_a;
    logic signed [DefWidth-1:0] offset_b;
    logic [DefWidth-2:0]        modulus;
  } lcs_in_t;

  typedef struct packed {
    logic                solvable;
    logic [DefWidth-2:0] root;
    logic [DefWidth-2:0] period;
  } lcs_out_t;

endpackage

FILE: hdl/lcs_div.sv
module lcs_div #(
  parameter int unsigned W = lcs_pkg::DefWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, quot[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        count <= CW'(W);
        quot  <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        if (trial[W]) begin
          rem  <= {rem[W-2:0], quot[W-1]};
          quot <= {quot[W-2:0], 1'b0};
        end else begin
          rem  <= trial[W-1:0];
          quot <= {quot[W-2:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) busy && count == CW'(1) |=> done)
    else $error("divider missed done");
endmodule

FILE: hdl/lcs_seq.sv
module lcs_seq #(
  parameter int unsigned W = lcs_pkg::DefWidth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic signed [W-1:0] a_in,
  input  logic signed [W-1:0] b_in,
  input  logic [W-2:0]        m_in,
  output logic                running,
  output logic                fin,
  output logic                sol,
  output logic [W-2:0]        root_out,
  output logic [W-2:0]        per_out
);
  import lcs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_RA = 4'd1, S_RB = 4'd2, S_GCD = 4'd3,
                         S_CHK = 4'd4, S_PER = 4'd5, S_INV = 4'd6, S_INVU = 4'd7,
                         S_MUL = 4'd8, S_DONE = 4'd9, S_RED = 4'd10, S_FIX = 4'd11;

  logic [3:0]   state;
  logic [W-1:0] m, ar, nb, bmag, g, p, q, r0, r1, per, acc, pw, mq;
  logic signed [W:0] t0, t1;
  logic [1:0]   red;
  logic         aneg, bneg, dstart;
  logic [W-1:0] dnd, dvs, quot, rem;
  logic         dbusy, ddone;

  lcs_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(dnd), .divisor(dvs),
    .busy(dbusy), .done(ddone), .quot(quot), .rem(rem)
  );

  logic [W-1:0] amag;
  assign amag = a_in[W-1] ? W'(-a_in) : W'(a_in);
  // |t1 * quot| stays within the modulus, so the low bits carry the exact value
  logic signed [2*W+1:0] tq;
  assign tq = t1 * $signed({1'b0, quot});
  logic [W:0] addp;
  assign addp = {1'b0, acc} + {1'b0, pw};
  logic [W:0] dblp;
  assign dblp = {pw, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dstart <= 1'b0;
      fin    <= 1'b0;
    end else begin
      dstart <= 1'b0;
      fin    <= 1'b0;
      case (state)
        S_IDLE: if (go) begin
          m <= W'(m_in); sol <= 1'b0; root_out <= '0; per_out <= '0;
          aneg <= a_in[W-1];
          bneg <= b_in[W-1];
          bmag <= b_in[W-1] ? W'(-b_in) : W'(b_in);
          if (m_in == '0) state <= S_DONE;
          else begin
            dnd <= amag; dvs <= W'(m_in); dstart <= 1'b1; state <= S_RA;
          end
        end
        S_RA: if (ddone) begin
          ar <= (aneg && rem != '0) ? m - rem : rem;
          dnd <= bmag; dvs <= m; dstart <= 1'b1; state <= S_RB;
        end
        S_RB: if (ddone) begin
          // -b mod m
          nb <= (!bneg && rem != '0) ? m - rem : rem;
          p <= m; q <= ar;
          state <= S_GCD;
        end
        S_GCD: if (!dbusy && !dstart) begin
          if (q == '0) begin
            g <= p; dnd <= nb; dvs <= p; dstart <= 1'b1; state <= S_CHK;
          end else if (ddone) begin
            p <= q; q <= rem;
          end else begin
            dnd <= p; dvs <= q; dstart <= 1'b1;
          end
        end
        S_CHK: if (ddone) begin
          if (rem != '0) state <= S_DONE;
          else begin
            nb <= quot; dnd <= m; dvs <= g; dstart <= 1'b1; state <= S_PER;
          end
        end
        S_PER: if (ddone) begin
          per <= quot; dnd <= ar; dvs <= g; dstart <= 1'b1; red <= 2'd0;
          state <= S_RED;
        end
        S_RED: if (ddone) begin
          // reduce a/g then b/g modulo per
          dnd <= quot; dvs <= per; dstart <= 1'b1; red <= red + 2'd1;
          state <= S_FIX;
        end
        S_FIX: if (ddone) begin
          if (red == 2'd1) begin
            r1 <= rem; dnd <= nb; dvs <= per; dstart <= 1'b1; red <= 2'd2;
          end else begin
            mq <= rem; r0 <= per; t0 <= '0; t1 <= (W+1)'(1); state <= S_INV;
          end
        end
        S_INV: if (!dbusy && !dstart) begin
          if (r1 == '0) begin
            pw <= t0[W] ? W'(t0 + $signed({1'b0, per})) : W'(t0);
            acc <= '0; state <= S_MUL;
          end else if (ddone) begin
            state <= S_INVU;
          end else begin
            dnd <= r0; dvs <= r1; dstart <= 1'b1;
          end
        end
        S_INVU: begin
          r0 <= r1; r1 <= rem;
          t0 <= t1;
          t1 <= t0 - $signed(tq[W:0]);
          state <= S_INV;
        end
        S_MUL: begin
          // shift-and-add modular product, one multiplier bit a cycle
          if (mq == '0) begin
            sol <= 1'b1; root_out <= (W-1)'(acc); per_out <= (W-1)'(per);
            state <= S_DONE;
          end else begin
            if (mq[0]) acc <= (addp >= {1'b0, per}) ? W'(addp - {1'b0, per}) : W'(addp);
            pw <= (dblp >= {1'b0, per}) ? W'(dblp - {1'b0, per}) : W'(dblp);
            mq <= mq >> 1;
          end
        end
        S_DONE: begin
          fin <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign running = (state != S_IDLE);

  assert property (@(posedge clk) disable iff (rst) fin |-> state == S_IDLE)
    else $error("finish outside idle");
  assert property (@(posedge clk) disable iff (rst) state == S_DONE |=> fin)
    else $error("missed finish");
  assert property (@(posedge clk) disable iff (rst) state == S_IDLE && go |=> state != S_IDLE)
    else $error("did not start");
endmodule

FILE: hdl/linear_congruence_solver.sv
// channel  | ports                       | transfer
// input    | start, busy, in_item        | start && !busy at clk edge
// result   | done, out_item              | done high for one cycle
// solves a*x + b = 0 mod m with a shared serial divider, one quotient bit a cycle
// the work is 7 fixed divisions, up to ~45 gcd steps and as many inverse steps,
// each holding one division, then a shift-and-add multiply; a zero modulus skips it all
// rst is synchronous and returns the sequencer to idle
// busy is high from the transfer until the result strobe; the receiver cannot stall
module linear_congruence_solver (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lcs_pkg::lcs_in_t in_item,
  output logic             busy,
  output logic             done,
  output lcs_pkg::lcs_out_t out_item
);
  import lcs_pkg::*;

  logic running, fin, sol;
  logic [DefWidth-2:0] root_w, per_w;

  lcs_seq #(.W(DefWidth)) u_seq (
    .clk(clk), .rst(rst), .go(start && !busy),
    .a_in(in_item.coef_a), .b_in(in_item.offset_b), .m_in(in_item.modulus),
    .running(running), .fin(fin), .sol(sol), .root_out(root_w), .per_out(per_w)
  );

  assign busy = running;
  assign done = fin;
  assign out_item.solvable = sol;
  assign out_item.root = root_w;
  assign out_item.period = per_w;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  assert property (@(posedge clk) disable iff (rst) done && !out_item.solvable |->
    out_item.root == '0 && out_item.period == '0)
    else $error("nonzero fields without root");
  assert property (@(posedge clk) disable iff (rst) done && out_item.solvable |->
    out_item.root < out_item.period)
    else $error("root out of range");
endmodule

FILE: test/tb_linear_congruence_solver.sv
module tb_linear_congruence_solver;
  import lcs_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  lcs_in_t  in_item;
  logic     busy;
  logic     done;
  lcs_out_t out_item;

  lcs_out_t expected_q[$];
  int       errors;
  int       n_sent;
  int       n_checked;
  int       n_solvable;
  bit       no_gaps;

  linear_congruence_solver i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .done     (done),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // residue of a signed 32-bit value modulo m
  function automatic longint unsigned sres(logic signed [31:0] v, longint unsigned m);
    longint signed sv;
    longint signed r;
    sv = v;
    r = sv % longint'(m);
    if (r < 0) r += longint'(m);
    return longint'(r);
  endfunction

  function automatic lcs_out_t solve_congruence(lcs_in_t it);
    lcs_out_t        res;
    longint unsigned m, ar, nb, g, p, q, t, per;
    longint signed   r0, r1, s0, s1, qq, tmp, inv;
    longint unsigned acc, x, y;
    res = '0;
    m = it.modulus;
    if (m == 0) return res;
    ar = sres(it.coef_a, m);
    nb = sres(it.offset_b, m);
    nb = (nb != 0) ? m - nb : 0;
    p = ar;
    q = m;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    g = p;
    if (nb % g != 0) return res;
    per = m / g;
    // inverse of a/g modulo the period
    r0 = per;
    r1 = (ar / g) % per;
    s0 = 0;
    s1 = 1;
    while (r1 != 0) begin
      qq = r0 / r1;
      tmp = r0 - qq * r1; r0 = r1; r1 = tmp;
      tmp = s0 - qq * s1; s0 = s1; s1 = tmp;
    end
    inv = s0 % longint'(per);
    if (inv < 0) inv += longint'(per);
    x = inv;
    y = (nb / g) % per;
    acc = (x * y) % per;  // both below 2^31, product fits 64 bits
    res.solvable = 1'b1;
    res.root = acc[30:0];
    res.period = per[30:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp, n_checked);
    errors++;
  endtask

  always @(posedge clk) begin
    lcs_out_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("result with no pending item");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_item.solvable !== e.solvable)
          report_mismatch("solvable", 64'(out_item.solvable), 64'(e.solvable));
        if (out_item.root !== e.root)
          report_mismatch("root", 64'(out_item.root), 64'(e.root));
        if (out_item.period !== e.period)
          report_mismatch("period", 64'(out_item.period), 64'(e.period));
        if (e.solvable) n_solvable++;
      end
      n_checked++;
    end
  end

  task automatic send_item(logic signed [31:0] a, logic signed [31:0] b, logic [30:0] m);
    lcs_in_t it;
    int      gap;
    it.coef_a = a;
    it.offset_b = b;
    it.modulus = m;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(solve_congruence(it));
    n_sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_item(32'sh8000_0000, 32'sh8000_0001, 31'h7fff_ffff);
    send_item(32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff);
    send_item(32'sh8000_0000, 32'sh0000_0000, 31'h7fff_fffe);
    send_item(32'sh8000_0000, 32'sh8000_0000, 31'd3);
    send_item(32'sh7fff_ffff, 32'sh8000_0000, 31'h4000_0000);
    send_item(-32'sd1, 32'sd1, 31'd1);
    send_item(32'sd1, -32'sd1, 31'h7fff_fffe);
  endtask

  task automatic test_special_cases();
    send_item(32'sd5, 32'sd3, 31'd0);      // zero modulus
    send_item(32'sd4, 32'sd1, 31'd6);      // gcd does not divide b
    send_item(32'sd0, 32'sd12, 31'd6);     // zero multiplier, m divides b
    send_item(32'sd0, 32'sd7, 31'd6);      // zero multiplier, no root
    send_item(32'sd6, 32'sd3, 31'd3);      // period of one
    send_item(32'sd14, 32'sd30, 31'd100);
    send_item(-32'sd3, 32'sd2, 31'd7);
    send_item(32'sd9, -32'sd6, 31'd15);
    send_item(32'sd0, 32'sd0, 31'd1);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      default: return $urandom & 32'hfffff000;  // many common factors
    endcase
  endfunction

  task automatic test_random(int count);
    logic signed [31:0] a, b;
    logic [30:0]        m;
    int                 g;
    for (int i = 0; i < count; i++) begin
      a = rand_word();
      b = rand_word();
      case ($urandom_range(0, 3))
        0: m = 31'($urandom);
        1: m = 31'($urandom_range(1, 64));
        2: m = 31'($urandom & 32'h7fff_f000);
        default: m = 31'($urandom_range(1, 1000) * $urandom_range(1, 1000));
      endcase
      // bias toward solvable items by making b a multiple of a shared factor
      if ($urandom_range(0, 1)) begin
        g = $urandom_range(1, 64);
        a = a * g;
        b = b * g;
        m = 31'(m * g);
      end
      if (b == 32'sh8000_0000) b = 32'sh8000_0001;
      if (m == 0 && $urandom_range(0, 7) != 0) m = 31'd1;
      send_item(a, b, m);
      if (i == count / 2) wait_drained();  // sender holds off until all results are in
    end
  endtask

  initial begin
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_solvable = 0;
    no_gaps = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_random(300);
    no_gaps = 1'b1;
    test_random(55);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d items, %0d solvable, extremes and special moduli included",
             n_sent, n_solvable);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #60000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
